>>> sv/hkc_pkg.sv
// Shared types and constants for the hash keystream cipher.
package hkc_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned IV_WORDS  = 2;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam int unsigned PRIME_SHIFT  = 40;
  localparam int unsigned XS_SHIFT     = 33;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IV0  = 3'd4;
  localparam logic [2:0] REG_IV1  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HASH = 4'b0010,
    ST_MIX  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef logic [63:0] lane_t;

  function automatic logic [8:0] mix_const(input logic [1:0] idx);
    logic [8:0] c;
    unique case (idx)
      2'd0: c = 9'd31;
      2'd1: c = 9'd37;
      2'd2: c = 9'd41;
      2'd3: c = 9'd43;
      default: c = 9'd31;
    endcase
    return c;
  endfunction

  function automatic lane_t lane_init(input logic [1:0] idx);
    return FNV_BASIS ^ {54'b0, idx, 8'h00};
  endfunction

endpackage

>>> sv/hash_keystream_cipher_top.sv
// Hash keystream cipher top level: APB registers, sequencer, lane store, output beat register.
// A byte inside a block is XORed with the keystream and registered the cycle after it is
// accepted; a byte opening a block first runs the hash, mix and out states. Lane updates go
// one per cycle via the single multiply-add unit; in-block bytes one per cycle unless stalled.
// Reset clears position, block counter, registers and control; lane store is not reset.
module hash_keystream_cipher_top #(
  parameter int unsigned KEY_BYTES = 32,
  parameter int unsigned IV_BYTES  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hkc_pkg::ADDR_W-1:0]  paddr,
  input  logic [hkc_pkg::DATA_W-1:0]  pwdata,
  output logic [hkc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_in_i,
  input  logic                        first_in_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  data_out_o,
  output logic                        last_out_o
);
  import hkc_pkg::*;

  localparam int unsigned TOTAL_BYTES = KEY_BYTES + IV_BYTES;
  localparam int unsigned BCNT_W      = $clog2(TOTAL_BYTES);
  localparam logic [BCNT_W-1:0] BIDX_LAST = BCNT_W'(TOTAL_BYTES - 1);
  localparam logic [BCNT_W-1:0] KEY_END   = BCNT_W'(KEY_BYTES);
  localparam logic [3:0]        IV_LAST   = 4'(IV_BYTES - 1);

  lane_t key_q [KEY_WORDS];
  lane_t iv_q  [IV_WORDS];
  lane_t lanes_q [NUM_LANES];

  state_e            state_q;
  logic [1:0]        lane_q;
  logic [BCNT_W-1:0] bidx_q;
  logic [4:0]        pos_q;
  logic [7:0]        cnt_q;
  logic [7:0]        din_q;
  logic              last_q;
  logic              ovalid_q;
  logic [7:0]        dout_q;
  logic              lout_q;

  logic              cfg_wr;
  logic [2:0]        reg_idx;
  logic              accept;
  logic [4:0]        pos_eff;
  logic [7:0]        cnt_eff;
  logic [7:0]        ks_byte;
  logic              new_block;
  logic [4:0]        pos_src;
  logic [7:0]        cnt_src;
  logic              last_src;
  logic [4:0]        pos_nxt;
  logic [7:0]        cnt_nxt;
  logic [4:0]        key_idx;
  logic [3:0]        iv_idx;
  logic [7:0]        key_byte;
  logic [7:0]        iv_byte;
  logic [7:0]        hbyte;
  lane_t             mac_a;
  logic [8:0]        mac_c;
  lane_t             mac_add;
  lane_t             mac_y;
  lane_t             lane_new;

  // APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_KEY0: prdata = key_q[0];
      REG_KEY1: prdata = key_q[1];
      REG_KEY2: prdata = key_q[2];
      REG_KEY3: prdata = key_q[3];
      REG_IV0:  prdata = iv_q[0];
      REG_IV1:  prdata = iv_q[1];
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
      for (int i = 0; i < IV_WORDS; i++) iv_q[i] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY0: key_q[0] <= pwdata;
        REG_KEY1: key_q[1] <= pwdata;
        REG_KEY2: key_q[2] <= pwdata;
        REG_KEY3: key_q[3] <= pwdata;
        REG_IV0:  iv_q[0]  <= pwdata;
        REG_IV1:  iv_q[1]  <= pwdata;
        default: ;
      endcase
    end
  end

  // Input side
  assign in_ready_o = (state_q == ST_IDLE) && (!ovalid_q || out_ready_i);
  assign accept     = in_valid_i & in_ready_o;
  assign pos_eff    = first_in_i ? 5'd0 : pos_q;
  assign cnt_eff    = first_in_i ? 8'd0 : cnt_q;
  assign new_block  = (pos_eff == 5'd0);
  assign ks_byte    = 8'(lanes_q[pos_eff[4:3]] >> {pos_eff[2:0], 3'b000});

  // Position / counter advance
  always_comb begin
    if (state_q == ST_OUT) begin
      pos_src  = 5'd0;
      cnt_src  = cnt_q;
      last_src = last_q;
    end else begin
      pos_src  = pos_eff;
      cnt_src  = cnt_eff;
      last_src = last_in_i;
    end
    if (last_src) begin
      pos_nxt = 5'd0;
      cnt_nxt = 8'd0;
    end else begin
      pos_nxt = pos_src + 5'd1;
      cnt_nxt = (pos_src == 5'd31) ? cnt_src + 8'd1 : cnt_src;
    end
  end

  // Hash byte source: key bytes, then IV bytes, last IV byte folds in the counter
  assign key_idx  = 5'(bidx_q);
  assign iv_idx   = 4'(bidx_q - KEY_END);
  assign key_byte = 8'(key_q[key_idx[4:3]] >> {key_idx[2:0], 3'b000});
  assign iv_byte  = 8'(iv_q[iv_idx[3]] >> {iv_idx[2:0], 3'b000});

  always_comb begin
    if (bidx_q < KEY_END) begin
      hbyte = key_byte;
    end else if (iv_idx == IV_LAST) begin
      hbyte = iv_byte ^ cnt_q;
    end else begin
      hbyte = iv_byte;
    end
  end

  // Shared multiply-add operands; lane 0 is always the one being updated
  always_comb begin
    if (state_q == ST_MIX) begin
      mac_a   = lanes_q[1];
      mac_c   = mix_const(lane_q);
      mac_add = lanes_q[0];
    end else begin
      mac_a   = lanes_q[0] ^ {56'b0, hbyte};
      mac_c   = FNV_PRIME_LO;
      mac_add = mac_a << PRIME_SHIFT;
    end
  end

  hkc_mac u_mac (
    .a_i   (mac_a),
    .c_i   (mac_c),
    .add_i (mac_add),
    .y_o   (mac_y)
  );

  assign lane_new = (state_q == ST_MIX) ? mac_y : (mac_y ^ (mac_y >> XS_SHIFT));

  // Lane store: rotates by one lane per update
  always_ff @(posedge clk_i) begin
    if (accept && new_block) begin
      for (int i = 0; i < NUM_LANES; i++) lanes_q[i] <= lane_init(2'(i));
    end else if (state_q == ST_HASH || state_q == ST_MIX) begin
      for (int i = 0; i < NUM_LANES - 1; i++) lanes_q[i] <= lanes_q[i+1];
      lanes_q[NUM_LANES-1] <= lane_new;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
      bidx_q  <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      din_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (new_block) begin
              state_q <= ST_HASH;
              lane_q  <= '0;
              bidx_q  <= '0;
              pos_q   <= 5'd0;
              cnt_q   <= cnt_eff;
              din_q   <= data_in_i;
              last_q  <= last_in_i;
            end else begin
              pos_q <= pos_nxt;
              cnt_q <= cnt_nxt;
            end
          end
        end
        ST_HASH: begin
          lane_q <= lane_q + 2'd1;
          if (lane_q == 2'd3) begin
            if (bidx_q == BIDX_LAST) begin
              state_q <= ST_MIX;
              bidx_q  <= '0;
            end else begin
              bidx_q <= bidx_q + 1'b1;
            end
          end
        end
        ST_MIX: begin
          lane_q <= lane_q + 2'd1;
          if (lane_q == 2'd3) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          state_q <= ST_IDLE;
          pos_q   <= pos_nxt;
          cnt_q   <= cnt_nxt;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      dout_q   <= '0;
      lout_q   <= 1'b0;
    end else if (accept && !new_block) begin
      ovalid_q <= 1'b1;
      dout_q   <= data_in_i ^ ks_byte;
      lout_q   <= last_in_i;
    end else if (state_q == ST_OUT) begin
      ovalid_q <= 1'b1;
      dout_q   <= din_q ^ lanes_q[0][7:0];
      lout_q   <= last_q;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign data_out_o  = dout_q;
  assign last_out_o  = lout_q;

endmodule

>>> sv/hkc_mac.sv
// Shared multiply-add unit: y = a * c + addend, low 64 bits.
module hkc_mac (
  input  hkc_pkg::lane_t a_i,
  input  logic [8:0]     c_i,
  input  hkc_pkg::lane_t add_i,
  output hkc_pkg::lane_t y_o
);
  import hkc_pkg::*;

  logic [72:0] prod;

  assign prod = {9'b0, a_i} * {64'b0, c_i};
  assign y_o  = prod[63:0] + add_i;

endmodule

>>> sim/hash_keystream_cipher_top_tb.sv
// Self-checking testbench for hash_keystream_cipher_top: APB key/IV setup, byte stream, scoreboard.
module hash_keystream_cipher_top_tb;
  import hkc_pkg::*;

  localparam int unsigned KEY_BYTES    = 32;
  localparam int unsigned IV_BYTES     = 16;
  localparam logic [63:0] FNV_OFFSET   = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MULT     = 64'h0000_0100_0000_01b3;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_BYTES  = 150;
  localparam int unsigned LONG_BYTES   = 3 * 32 + 8;

  localparam logic [2:0] REG_ORDER [6] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3,
                                           REG_IV0, REG_IV1};

  typedef enum int {KEYS_ZERO, KEYS_ONES, KEYS_CHECKER, KEYS_RANDOM} key_setting_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } dir_byte_t;

  // data, first, last
  localparam dir_byte_t DIR_BYTES [18] = '{
    '{8'h00, 1'b1, 1'b0},  // first byte after reset, all-zero key
    '{8'hff, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b1},  // end of message
    '{8'h5a, 1'b0, 1'b0},  // new message without first marker
    '{8'ha5, 1'b0, 1'b0},
    '{8'h3c, 1'b1, 1'b0},  // first marker mid-message restarts
    '{8'hc3, 1'b0, 1'b0},
    '{8'hff, 1'b1, 1'b1},  // single-byte messages
    '{8'hff, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b1},
    '{8'h00, 1'b0, 1'b1},
    '{8'h7f, 1'b0, 1'b0},
    '{8'h55, 1'b0, 1'b0},
    '{8'haa, 1'b0, 1'b0},
    '{8'hfe, 1'b1, 1'b0},
    '{8'h01, 1'b0, 1'b0},
    '{8'hfe, 1'b0, 1'b1}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_in_i;
  logic                first_in_i;
  logic                last_in_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          data_out_o;
  logic                last_out_o;

  logic [63:0]         key_r [4];
  logic [63:0]         iv_r [2];
  logic [4:0]          pos_r = '0;
  logic [7:0]          ctr_r = '0;
  logic [3:0][63:0]    keystream_r;
  logic [7:0]          ctr_peak = '0;

  cipher_beat_t        cipher_bytes_q [$];
  cipher_beat_t        exp_beat;
  int unsigned         quiet_cycles = 0;
  int unsigned         mismatches = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         messages_sent = 0;
  int unsigned         key_settings = 1;
  int unsigned         idle_pct = 0;
  int unsigned         stall_pct = 0;

  hash_keystream_cipher_top #(
    .KEY_BYTES (KEY_BYTES),
    .IV_BYTES  (IV_BYTES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_in_i   (data_in_i),
    .first_in_i  (first_in_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .last_out_o  (last_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [3:0][63:0] hash_block(input logic [7:0] ctr);
    logic [3:0][63:0] h;
    logic [63:0]      t;
    logic [7:0]       b;
    for (int j = 0; j < 4; j++) h[j] = FNV_OFFSET ^ (64'(j) << 8);
    for (int k = 0; k < KEY_BYTES + IV_BYTES; k++) begin
      if (k < KEY_BYTES) begin
        b = key_r[k / 8][8 * (k % 8) +: 8];
      end else begin
        b = iv_r[(k - KEY_BYTES) / 8][8 * ((k - KEY_BYTES) % 8) +: 8];
        if (k == KEY_BYTES + IV_BYTES - 1) b = b ^ ctr;
      end
      for (int j = 0; j < 4; j++) begin
        t = (h[j] ^ {56'b0, b}) * FNV_MULT;
        h[j] = t ^ (t >> 33);
      end
    end
    h[0] = h[0] + h[1] * 64'd31;
    h[1] = h[1] + h[2] * 64'd37;
    h[2] = h[2] + h[3] * 64'd41;
    h[3] = h[3] + h[0] * 64'd43;
    return h;
  endfunction

  function automatic cipher_beat_t encrypt_byte(input logic [7:0] d, input logic f,
                                                input logic l);
    cipher_beat_t r;
    if (f) begin
      pos_r = '0;
      ctr_r = '0;
    end
    if (pos_r == '0) keystream_r = hash_block(ctr_r);
    r.data = d ^ keystream_r[pos_r[4:3]][8 * pos_r[2:0] +: 8];
    r.last = l;
    if (l) begin
      pos_r = '0;
      ctr_r = '0;
    end else begin
      pos_r = pos_r + 5'd1;
      if (pos_r == '0) begin
        ctr_r = ctr_r + 8'd1;
        if (ctr_r > ctr_peak) ctr_peak = ctr_r;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (cipher_bytes_q.size() == 0) begin
          $error("unexpected beat: data_out %h last_out %b", data_out_o, last_out_o);
          mismatches++;
        end else begin
          exp_beat = cipher_bytes_q.pop_front();
          if (data_out_o !== exp_beat.data) begin
            $error("data_out: expected %h, got %h", exp_beat.data, data_out_o);
            mismatches++;
          end
          if (last_out_o !== exp_beat.last) begin
            $error("last_out: expected %b, got %b", exp_beat.last, last_out_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o)
        cipher_bytes_q.push_back(encrypt_byte(data_in_i, first_in_i, last_in_i));
      quiet_cycles <= ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                       (psel && penable && pready)) ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("hash_keystream_cipher_top_tb: errors");
    $finish;
  end

  task automatic check_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== value) begin
      $error("prdata: expected %h, got %h", value, prdata);
      mismatches++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_KEY0: key_r[0] = value;
      REG_KEY1: key_r[1] = value;
      REG_KEY2: key_r[2] = value;
      REG_KEY3: key_r[3] = value;
      REG_IV0:  iv_r[0] = value;
      REG_IV1:  iv_r[1] = value;
      default: ;
    endcase
    check_reg(idx, value);
  endtask

  function automatic logic [63:0] key_pattern(input key_setting_e mode, input int idx);
    case (mode)
      KEYS_ZERO:    return '0;
      KEYS_ONES:    return '1;
      KEYS_CHECKER: return idx[0] ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa;
      default:      return {$urandom, $urandom};
    endcase
  endfunction

  task automatic program_keys(input key_setting_e mode);
    for (int i = 0; i < 6; i++) write_reg(REG_ORDER[i], key_pattern(mode, i));
    key_settings++;
  endtask

  task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
    int unsigned gap;
    gap = 0;
    in_valid_i <= 1'b1;
    data_in_i  <= d;
    first_in_i <= f;
    last_in_i  <= l;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cipher_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  // broken messages carry sparse, random first/last markers
  task automatic send_message(input int unsigned len, input bit broken);
    logic f;
    logic l;
    for (int unsigned i = 0; i < len; i++) begin
      if (broken) begin
        f = ($urandom_range(9) == 0);
        l = ($urandom_range(9) == 0);
      end else begin
        f = (i == 0);
        l = (i == len - 1);
      end
      send_byte(8'($urandom_range(255)), f, l);
    end
    messages_sent++;
  endtask

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned goal;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      if ($urandom_range(99) < 80)
        send_message(($urandom_range(7) == 0) ? $urandom_range(33, 96) : $urandom_range(1, 32),
                     1'b0);
      else
        send_message($urandom_range(1, 24), 1'b1);
      if ($urandom_range(29) == 0) drain_results();
    end
  endtask

  initial begin
    dir_byte_t row;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    data_in_i  = '0;
    first_in_i = 1'b0;
    last_in_i  = 1'b0;
    for (int i = 0; i < 4; i++) key_r[i] = '0;
    for (int i = 0; i < 2; i++) iv_r[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 6; i++) check_reg(REG_ORDER[i], '0);

    for (int i = 0; i < 18; i++) begin
      row = DIR_BYTES[i];
      send_byte(row.data, row.first, row.last);
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin program_keys(KEYS_ONES);    idle_pct = 0;  stall_pct = 0;  end
        1: begin program_keys(KEYS_RANDOM);  idle_pct = 72; stall_pct = 0;  end
        2: begin program_keys(KEYS_CHECKER); idle_pct = 0;  stall_pct = 72; end
        default: begin program_keys(KEYS_RANDOM); idle_pct = 24; stall_pct = 24; end
      endcase
      random_traffic(PHASE_BYTES);
      drain_results();
    end

    // one message spanning several blocks
    program_keys(KEYS_RANDOM);
    idle_pct  = 0;
    stall_pct = 0;
    send_message(LONG_BYTES, 1'b0);
    drain_results();
    program_keys(KEYS_ZERO);
    random_traffic(40);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d bytes in %0d messages under %0d key/IV settings and four stall mixes.",
             bytes_sent, messages_sent, key_settings);
    $display("Highest block counter seen: %0d.", ctr_peak);
    if (mismatches == 0) begin
      $display("hash_keystream_cipher_top_tb: clean");
    end else begin
      $display("hash_keystream_cipher_top_tb: errors");
    end
    $finish;
  end

endmodule
